// ===== sv/nbgu_pkg.sv =====
// ----------------------------------------------------------------------------
// nbgu_pkg: shared types, codes and saturating helpers
// Fixed-point words, opcodes, register indexes and the saturating arithmetic
// used by the body update sequencer and its checker.
// ----------------------------------------------------------------------------
package nbgu_pkg;

   typedef logic [63:0]        word_type;
   typedef logic signed [63:0] sword_type;
   typedef logic [62:0]        umag_type;
   typedef logic [2:0]         opcode_type;
   typedef logic [0:0]         regidx_type;

   localparam word_type SIGN_WORD = 64'h8000_0000_0000_0000;
   localparam word_type MAX_WORD  = 64'h7FFF_FFFF_FFFF_FFFF;

   localparam opcode_type OP_LOAD   = 3'd0;
   localparam opcode_type OP_CLEAR  = 3'd1;
   localparam opcode_type OP_GRAV   = 3'd2;
   localparam opcode_type OP_VEL    = 3'd3;
   localparam opcode_type OP_POS    = 3'd4;
   localparam opcode_type OP_COLL   = 3'd5;
   localparam opcode_type OP_ABSORB = 3'd6;
   localparam opcode_type OP_DEACT  = 3'd7;

   localparam regidx_type REG_GAIN = 1'b0;
   localparam regidx_type REG_STEP = 1'b1;

   // magnitude of a two's complement word (most negative gives 2^63)
   function automatic word_type mag64(input word_type x);
      return x[63] ? (64'd0 - x) : x;
   endfunction

   function automatic word_type sat_add64(input word_type a, input word_type b);
      word_type r;
      r = a + b;
      if ((a[63] == b[63]) && (r[63] != a[63])) return a[63] ? SIGN_WORD : MAX_WORD;
      return r;
   endfunction

   function automatic word_type sat_sub64(input word_type a, input word_type b);
      word_type r;
      r = a - b;
      if ((a[63] != b[63]) && (r[63] != a[63])) return a[63] ? SIGN_WORD : MAX_WORD;
      return r;
   endfunction

   // apply sign to a magnitude, saturating; over flags bits above the word
   function automatic word_type sat_mag64(input logic neg, input logic over,
                                          input word_type lo);
      if (neg) return (over || (lo > SIGN_WORD)) ? SIGN_WORD : (64'd0 - lo);
      return (over || (lo > MAX_WORD)) ? MAX_WORD : lo;
   endfunction

   // signed a >= b
   function automatic logic sge64(input word_type a, input word_type b);
      return {~a[63], a[62:0]} >= {~b[63], b[62:0]};
   endfunction

endpackage

// ===== sv/nbgu_mul.sv =====
// ----------------------------------------------------------------------------
// nbgu_mul: bit-serial unsigned multiplier
// 128 x 64 shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module nbgu_mul (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] a,
   input  logic [63:0]  b,
   output logic         done,
   output logic [191:0] prod
);

   logic [127:0] a_ff;
   logic [127:0] acc_ff;
   logic [63:0]  lo_ff;
   logic [5:0]   cnt_ff;
   logic         busy_ff;
   logic         done_ff;
   logic [128:0] sum;

   // add the multiplicand when the low multiplier bit is set
   assign sum = {1'b0, acc_ff} + (lo_ff[0] ? {1'b0, a_ff} : 129'd0);

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // shift the partial product right one bit per cycle
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         acc_ff <= 128'd0;
         lo_ff  <= b;
      end else if (busy_ff) begin
         acc_ff <= sum[128:1];
         lo_ff  <= {sum[0], lo_ff[63:1]};
      end
   end

   assign done = done_ff;
   assign prod = {acc_ff, lo_ff};

endmodule

// ===== sv/nbgu_div.sv =====
// ----------------------------------------------------------------------------
// nbgu_div: bit-serial restoring divider
// 128-bit dividend by 64-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nbgu_div (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] num,
   input  logic [63:0]  den,
   output logic         done,
   output logic [127:0] quo
);

   logic [127:0] num_ff;
   logic [63:0]  rem_ff;
   logic [63:0]  den_ff;
   logic [6:0]   cnt_ff;
   logic         busy_ff;
   logic         done_ff;
   logic [64:0]  trial;
   logic [64:0]  diff;
   logic         ge;

   // next partial remainder and trial subtract
   assign trial = {rem_ff, num_ff[127]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 7'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 7'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 7'd1;
            if (cnt_ff == 7'd127) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // dividend shifts out at the top, quotient bits shift in at the bottom
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         rem_ff <= 64'd0;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[63:0] : trial[63:0];
         num_ff <= {num_ff[126:0], ge};
      end
   end

   assign done = done_ff;
   assign quo  = num_ff;

endmodule

// ===== sv/nbody_body_gravity_update.sv =====
// ----------------------------------------------------------------------------
// nbody_body_gravity_update: one body of a fixed-point n-body simulation
// Holds mass, radius, position, velocity and acceleration of one body and runs
// one of eight operations per item on a shared bit-serial multiplier, a
// bit-serial divider and a two-bit-per-cycle square root.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | opcode, other body fields
//   rsp     | out       | rsp_valid/rsp_stall  | body after the step, flags
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// Absorb's cube root tries one bit at a time with two multiplies per bit.
// One item is in work at a time; req_stall is high from acceptance until
// the result is placed in the output register. Reset is synchronous and
// clears the body state and sets G and dt to 1.0. csr_ready is always high.
// ----------------------------------------------------------------------------
module nbody_body_gravity_update #(
   parameter int FRAC_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  nbgu_pkg::opcode_type  req_opcode,
   input  nbgu_pkg::sword_type   req_other_mass,
   input  nbgu_pkg::umag_type    req_other_radius,
   input  nbgu_pkg::sword_type   req_other_pos_x,
   input  nbgu_pkg::sword_type   req_other_pos_y,
   input  nbgu_pkg::sword_type   req_other_pos_z,
   input  nbgu_pkg::sword_type   req_other_vel_x,
   input  nbgu_pkg::sword_type   req_other_vel_y,
   input  nbgu_pkg::sword_type   req_other_vel_z,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output nbgu_pkg::sword_type   rsp_body_mass,
   output nbgu_pkg::umag_type    rsp_body_radius,
   output nbgu_pkg::sword_type   rsp_pos_x,
   output nbgu_pkg::sword_type   rsp_pos_y,
   output nbgu_pkg::sword_type   rsp_pos_z,
   output nbgu_pkg::sword_type   rsp_vel_x,
   output nbgu_pkg::sword_type   rsp_vel_y,
   output nbgu_pkg::sword_type   rsp_vel_z,
   output logic                  rsp_is_active,
   output logic                  rsp_collided,
   output logic                  rsp_absorbed,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  nbgu_pkg::regidx_type  csr_index,
   input  nbgu_pkg::umag_type    csr_wdata
);

   import nbgu_pkg::*;

   // sequencer states
   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_SSQ  = 5'd1;
   localparam logic [4:0] S_SQRT = 5'd2;
   localparam logic [4:0] S_R2   = 5'd3;
   localparam logic [4:0] S_R3   = 5'd4;
   localparam logic [4:0] S_KDIV = 5'd5;
   localparam logic [4:0] S_GACC = 5'd6;
   localparam logic [4:0] S_VEL1 = 5'd7;
   localparam logic [4:0] S_VEL2 = 5'd8;
   localparam logic [4:0] S_POS  = 5'd9;
   localparam logic [4:0] S_C1A  = 5'd10;
   localparam logic [4:0] S_C1B  = 5'd11;
   localparam logic [4:0] S_C2A  = 5'd12;
   localparam logic [4:0] S_C2B  = 5'd13;
   localparam logic [4:0] S_CBA  = 5'd14;
   localparam logic [4:0] S_CBB  = 5'd15;
   localparam logic [4:0] S_MV1  = 5'd16;
   localparam logic [4:0] S_MV2  = 5'd17;
   localparam logic [4:0] S_MDIV = 5'd18;
   localparam logic [4:0] S_DONE = 5'd19;

   // control and body state
   logic [4:0] state_ff, state_in;
   logic       wait_ff, wait_in;
   logic       rsp_valid_ff, rsp_valid_in;
   umag_type   gain_ff, gain_in;
   umag_type   step_ff, step_in;
   word_type   mass_ff, mass_in;
   umag_type   rad_ff, rad_in;
   word_type   pos_ff[3], pos_in[3];
   word_type   vel_ff[3], vel_in[3];
   word_type   acc_ff[3], acc_in[3];

   // item and working registers
   opcode_type op_ff, op_in;
   word_type   om_ff, om_in;
   umag_type   orad_ff, orad_in;
   word_type   ovel_ff[3], ovel_in[3];
   word_type   d_ff[3], d_in[3];
   logic [1:0] idx_ff, idx_in;
   logic [127:0] ssq_ff, ssq_in;
   logic [64:0]  srem_ff, srem_in;
   word_type   root_ff, root_in;
   logic [5:0] cnt_ff, cnt_in;
   word_type   r3_ff, r3_in;
   word_type   k_ff, k_in;
   word_type   tot_ff, tot_in;
   word_type   pacc_ff, pacc_in;
   logic [127:0] sq_ff, sq_in;
   logic [191:0] cube_ff, cube_in;
   logic       coll_ff, coll_in;
   logic       absb_ff, absb_in;

   // registered result
   word_type   rsp_mass_ff;
   umag_type   rsp_rad_ff;
   word_type   rsp_pos_ff[3];
   word_type   rsp_vel_ff[3];
   logic       rsp_act_ff, rsp_coll_ff, rsp_absb_ff;
   logic       rsp_load;

   // shared units
   logic         mul_start, mul_done, uses_mul, mul_neg;
   logic [127:0] mul_a;
   logic [63:0]  mul_b;
   logic [191:0] mul_prod;
   logic         div_start, div_done, div_neg;
   logic [127:0] div_num;
   logic [63:0]  div_den;
   logic [127:0] div_quo;

   // derived values
   logic [127:0] prod_shr;
   logic         mul_over;
   word_type     smul_val, umul_val, div_val, cand;
   logic         req_accept;
   logic [66:0]  sq_trial, sq_rem;
   logic         sq_ge;

   nbgu_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   nbgu_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;

   // fractional rescale of a product, signed and unsigned saturation
   assign prod_shr = mul_prod[127:0] >> FRAC_BITS;
   assign mul_over = |prod_shr[127:64];
   assign smul_val = sat_mag64(mul_neg, mul_over, prod_shr[63:0]);
   assign umul_val = mul_over ? {64{1'b1}} : prod_shr[63:0];
   assign div_val  = sat_mag64(div_neg, |div_quo[127:64], div_quo[63:0]);
   assign cand     = root_ff | (64'd1 << cnt_ff);

   // square root step: two radicand bits per cycle
   assign sq_rem   = {srem_ff, ssq_ff[127:126]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign sq_ge    = sq_rem >= sq_trial;

   // multiplier and divider operands by state
   always_comb begin
      uses_mul = 1'b1;
      mul_a    = 128'd0;
      mul_b    = 64'd0;
      mul_neg  = 1'b0;
      div_num  = {64'd0, mag64(om_ff)} << FRAC_BITS;
      div_den  = r3_ff;
      div_neg  = om_ff[63];
      case (state_ff)
         S_SSQ: begin
            mul_a = {64'd0, mag64(d_ff[idx_ff])};
            mul_b = mag64(d_ff[idx_ff]);
         end
         S_R2: begin
            mul_a = {64'd0, root_ff};
            mul_b = root_ff;
         end
         S_R3: begin
            mul_a = {64'd0, r3_ff};
            mul_b = root_ff;
         end
         S_GACC: begin
            mul_a   = {64'd0, mag64(d_ff[idx_ff])};
            mul_b   = mag64(k_ff);
            mul_neg = d_ff[idx_ff][63] ^ k_ff[63];
         end
         S_VEL1: begin
            mul_a   = {64'd0, mag64(acc_ff[idx_ff])};
            mul_b   = {1'b0, gain_ff};
            mul_neg = acc_ff[idx_ff][63];
         end
         S_VEL2: begin
            mul_a   = {64'd0, mag64(pacc_ff)};
            mul_b   = {1'b0, step_ff};
            mul_neg = pacc_ff[63];
         end
         S_POS: begin
            mul_a   = {64'd0, mag64(vel_ff[idx_ff])};
            mul_b   = {1'b0, step_ff};
            mul_neg = vel_ff[idx_ff][63];
         end
         S_C1A: begin
            mul_a = {65'd0, rad_ff};
            mul_b = {1'b0, rad_ff};
         end
         S_C1B: begin
            mul_a = sq_ff;
            mul_b = {1'b0, rad_ff};
         end
         S_C2A: begin
            mul_a = {65'd0, orad_ff};
            mul_b = {1'b0, orad_ff};
         end
         S_C2B: begin
            mul_a = sq_ff;
            mul_b = {1'b0, orad_ff};
         end
         S_CBA: begin
            mul_a = {64'd0, cand};
            mul_b = cand;
         end
         S_CBB: begin
            mul_a = sq_ff;
            mul_b = cand;
         end
         S_MV1: begin
            mul_a   = {64'd0, mag64(vel_ff[idx_ff])};
            mul_b   = mag64(mass_ff);
            mul_neg = vel_ff[idx_ff][63] ^ mass_ff[63];
         end
         S_MV2: begin
            mul_a   = {64'd0, mag64(ovel_ff[idx_ff])};
            mul_b   = mag64(om_ff);
            mul_neg = ovel_ff[idx_ff][63] ^ om_ff[63];
         end
         S_MDIV: begin
            uses_mul = 1'b0;
            div_num  = {64'd0, mag64(pacc_ff)} << FRAC_BITS;
            div_den  = mag64(tot_ff);
            div_neg  = pacc_ff[63] ^ tot_ff[63];
         end
         default: uses_mul = 1'b0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      wait_in      = wait_ff;
      rsp_valid_in = rsp_valid_ff;
      gain_in      = gain_ff;
      step_in      = step_ff;
      mass_in      = mass_ff;
      rad_in       = rad_ff;
      op_in        = op_ff;
      om_in        = om_ff;
      orad_in      = orad_ff;
      idx_in       = idx_ff;
      ssq_in       = ssq_ff;
      srem_in      = srem_ff;
      root_in      = root_ff;
      cnt_in       = cnt_ff;
      r3_in        = r3_ff;
      k_in         = k_ff;
      tot_in       = tot_ff;
      pacc_in      = pacc_ff;
      sq_in        = sq_ff;
      cube_in      = cube_ff;
      coll_in      = coll_ff;
      absb_in      = absb_ff;
      mul_start    = 1'b0;
      div_start    = 1'b0;
      rsp_load     = 1'b0;
      for (int i = 0; i < 3; i++) begin
         pos_in[i]  = pos_ff[i];
         vel_in[i]  = vel_ff[i];
         acc_in[i]  = acc_ff[i];
         ovel_in[i] = ovel_ff[i];
         d_in[i]    = d_ff[i];
      end

      // result register drains independently
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      // configuration writes
      if (csr_valid) begin
         case (csr_index)
            REG_GAIN: gain_in = csr_wdata;
            REG_STEP: step_in = csr_wdata;
            default: ;
         endcase
      end

      // issue a multiply on entry to a multiply state
      if (uses_mul && !wait_ff) begin
         mul_start = 1'b1;
         wait_in   = 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in      = req_opcode;
               om_in      = req_other_mass;
               orad_in    = req_other_radius;
               ovel_in[0] = req_other_vel_x;
               ovel_in[1] = req_other_vel_y;
               ovel_in[2] = req_other_vel_z;
               d_in[0]    = sat_sub64(req_other_pos_x, pos_ff[0]);
               d_in[1]    = sat_sub64(req_other_pos_y, pos_ff[1]);
               d_in[2]    = sat_sub64(req_other_pos_z, pos_ff[2]);
               idx_in     = 2'd0;
               wait_in    = 1'b0;
               coll_in    = 1'b0;
               absb_in    = 1'b0;
               ssq_in     = 128'd0;
               state_in   = S_DONE;
               case (req_opcode)
                  OP_LOAD: begin
                     mass_in   = req_other_mass;
                     rad_in    = req_other_radius;
                     pos_in[0] = req_other_pos_x;
                     pos_in[1] = req_other_pos_y;
                     pos_in[2] = req_other_pos_z;
                     vel_in[0] = req_other_vel_x;
                     vel_in[1] = req_other_vel_y;
                     vel_in[2] = req_other_vel_z;
                     for (int i = 0; i < 3; i++) acc_in[i] = 64'd0;
                  end
                  OP_CLEAR: for (int i = 0; i < 3; i++) acc_in[i] = 64'd0;
                  OP_GRAV, OP_COLL: state_in = S_SSQ;
                  OP_VEL: state_in = S_VEL1;
                  OP_POS: state_in = S_POS;
                  OP_ABSORB: begin
                     if (sge64(mass_ff, req_other_mass)) begin
                        tot_in   = sat_add64(mass_ff, req_other_mass);
                        absb_in  = 1'b1;
                        state_in = S_C1A;
                     end
                  end
                  OP_DEACT: mass_in = (mass_ff == SIGN_WORD) ? MAX_WORD : (64'd0 - mass_ff);
                  default: ;
               endcase
            end
         end

         // sum of squared distance components
         S_SSQ: begin
            if (wait_ff && mul_done) begin
               wait_in = 1'b0;
               ssq_in  = ssq_ff + mul_prod[127:0];
               if (idx_ff == 2'd2) begin
                  idx_in   = 2'd0;
                  root_in  = 64'd0;
                  srem_in  = 65'd0;
                  cnt_in   = 6'd0;
                  state_in = S_SQRT;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end

         // floor square root, one result bit per cycle
         S_SQRT: begin
            srem_in = sq_ge ? 65'(sq_rem - sq_trial) : sq_rem[64:0];
            root_in = {root_ff[62:0], sq_ge};
            ssq_in  = ssq_ff << 2;
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               if (op_ff == OP_COLL) begin
                  coll_in  = root_in < ({1'b0, rad_ff} + {1'b0, orad_ff});
                  state_in = S_DONE;
               end else if (root_in == 64'd0) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_R2;
               end
            end
         end

         // cube of the distance, saturating
         S_R2: begin
            if (wait_ff && mul_done) begin
               wait_in  = 1'b0;
               r3_in    = umul_val;
               state_in = S_R3;
            end
         end
         S_R3: begin
            if (wait_ff && mul_done) begin
               wait_in  = 1'b0;
               r3_in    = umul_val;
               state_in = S_KDIV;
            end
         end

         // k = other mass / r^3
         S_KDIV: begin
            if (!wait_ff) begin
               if (mag64(om_ff) == 64'd0) begin
                  k_in     = 64'd0;
                  state_in = S_GACC;
               end else if (r3_ff == 64'd0) begin
                  k_in     = sat_mag64(om_ff[63], 1'b1, 64'd0);
                  state_in = S_GACC;
               end else begin
                  div_start = 1'b1;
                  wait_in   = 1'b1;
               end
            end else if (div_done) begin
               wait_in  = 1'b0;
               k_in     = div_val;
               state_in = S_GACC;
            end
         end

         // accel += d * k per component
         S_GACC: begin
            if (wait_ff && mul_done) begin
               wait_in        = 1'b0;
               acc_in[idx_ff] = sat_add64(acc_ff[idx_ff], smul_val);
               if (idx_ff == 2'd2) state_in = S_DONE;
               else idx_in = idx_ff + 2'd1;
            end
         end

         // vel += accel * G * dt per component
         S_VEL1: begin
            if (wait_ff && mul_done) begin
               wait_in  = 1'b0;
               pacc_in  = smul_val;
               state_in = S_VEL2;
            end
         end
         S_VEL2: begin
            if (wait_ff && mul_done) begin
               wait_in        = 1'b0;
               vel_in[idx_ff] = sat_add64(vel_ff[idx_ff], smul_val);
               if (idx_ff == 2'd2) begin
                  state_in = S_DONE;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = S_VEL1;
               end
            end
         end

         // pos += vel * dt per component
         S_POS: begin
            if (wait_ff && mul_done) begin
               wait_in        = 1'b0;
               pos_in[idx_ff] = sat_add64(pos_ff[idx_ff], smul_val);
               if (idx_ff == 2'd2) state_in = S_DONE;
               else idx_in = idx_ff + 2'd1;
            end
         end

         // sum of radius cubes, and the square of the cube root trial
         S_C1A, S_C2A, S_CBA: begin
            if (wait_ff && mul_done) begin
               wait_in  = 1'b0;
               sq_in    = mul_prod[127:0];
               state_in = state_ff + 5'd1;
            end
         end
         S_C1B: begin
            if (wait_ff && mul_done) begin
               wait_in  = 1'b0;
               cube_in  = mul_prod;
               state_in = S_C2A;
            end
         end
         S_C2B: begin
            if (wait_ff && mul_done) begin
               wait_in  = 1'b0;
               cube_in  = cube_ff + mul_prod;
               root_in  = 64'd0;
               cnt_in   = 6'd63;
               state_in = S_CBA;
            end
         end

         // cube root: keep the trial bit when its cube fits
         S_CBB: begin
            if (wait_ff && mul_done) begin
               wait_in = 1'b0;
               if (mul_prod <= cube_ff) root_in = cand;
               if (cnt_ff == 6'd0) begin
                  rad_in = (root_in > MAX_WORD) ? 63'(MAX_WORD) : root_in[62:0];
                  idx_in = 2'd0;
                  if (tot_ff != 64'd0) begin
                     state_in = S_MV1;
                  end else begin
                     mass_in  = tot_ff;
                     state_in = S_DONE;
                  end
               end else begin
                  cnt_in   = cnt_ff - 6'd1;
                  state_in = S_CBA;
               end
            end
         end

         // momentum of both bodies, divided by the total mass
         S_MV1: begin
            if (wait_ff && mul_done) begin
               wait_in  = 1'b0;
               pacc_in  = smul_val;
               state_in = S_MV2;
            end
         end
         S_MV2: begin
            if (wait_ff && mul_done) begin
               wait_in  = 1'b0;
               pacc_in  = sat_add64(pacc_ff, smul_val);
               state_in = S_MDIV;
            end
         end
         S_MDIV: begin
            if (!wait_ff && (mag64(pacc_ff) != 64'd0)) begin
               div_start = 1'b1;
               wait_in   = 1'b1;
            end else if (!wait_ff || div_done) begin
               wait_in        = 1'b0;
               vel_in[idx_ff] = wait_ff ? div_val : 64'd0;
               if (idx_ff == 2'd2) begin
                  mass_in  = tot_ff;
                  state_in = S_DONE;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = S_MV1;
               end
            end
         end

         // place the result once the output register is free
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gain_ff      <= 63'(64'd1 << FRAC_BITS);
         step_ff      <= 63'(64'd1 << FRAC_BITS);
         mass_ff      <= 64'd0;
         rad_ff       <= 63'd0;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= 64'd0;
            vel_ff[i] <= 64'd0;
            acc_ff[i] <= 64'd0;
         end
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
         gain_ff      <= gain_in;
         step_ff      <= step_in;
         mass_ff      <= mass_in;
         rad_ff       <= rad_in;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= pos_in[i];
            vel_ff[i] <= vel_in[i];
            acc_ff[i] <= acc_in[i];
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      om_ff   <= om_in;
      orad_ff <= orad_in;
      idx_ff  <= idx_in;
      ssq_ff  <= ssq_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      r3_ff   <= r3_in;
      k_ff    <= k_in;
      tot_ff  <= tot_in;
      pacc_ff <= pacc_in;
      sq_ff   <= sq_in;
      cube_ff <= cube_in;
      coll_ff <= coll_in;
      absb_ff <= absb_in;
      for (int i = 0; i < 3; i++) begin
         ovel_ff[i] <= ovel_in[i];
         d_ff[i]    <= d_in[i];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_mass_ff <= mass_ff;
         rsp_rad_ff  <= rad_ff;
         rsp_act_ff  <= !mass_ff[63] && (mass_ff != 64'd0);
         rsp_coll_ff <= coll_ff;
         rsp_absb_ff <= absb_ff;
         for (int i = 0; i < 3; i++) begin
            rsp_pos_ff[i] <= pos_ff[i];
            rsp_vel_ff[i] <= vel_ff[i];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_body_mass   = rsp_mass_ff;
   assign rsp_body_radius = rsp_rad_ff;
   assign rsp_pos_x       = rsp_pos_ff[0];
   assign rsp_pos_y       = rsp_pos_ff[1];
   assign rsp_pos_z       = rsp_pos_ff[2];
   assign rsp_vel_x       = rsp_vel_ff[0];
   assign rsp_vel_y       = rsp_vel_ff[1];
   assign rsp_vel_z       = rsp_vel_ff[2];
   assign rsp_is_active   = rsp_act_ff;
   assign rsp_collided    = rsp_coll_ff;
   assign rsp_absorbed    = rsp_absb_ff;

endmodule

// ===== sv/nbgu_check.sv =====
// ----------------------------------------------------------------------------
// nbgu_check: port-level checks for the body update block
// Watches the item channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module nbgu_check (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input nbgu_pkg::sword_type  rsp_body_mass,
   input logic                 rsp_is_active,
   input logic                 rsp_collided,
   input logic                 rsp_absorbed
);

   // one item at a time: an accepted item blocks the input next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after an item was accepted");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_body_mass))
      else $error("stalled result changed");

   // active flag follows the reported mass
   a_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_is_active == (!rsp_body_mass[63] && (rsp_body_mass != 64'sd0)))
      else $error("is_active does not match mass");

   // collide and absorb flags come from different operations
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_collided && rsp_absorbed))
      else $error("collided and absorbed both set");

endmodule

bind nbody_body_gravity_update nbgu_check u_nbgu_check (.*);

// ===== tb/nbody_body_gravity_update_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nbody_body_gravity_update_tb: self-checking bench for the body update block
// Drives directed and random steps through the request channel with random
// gaps and output stalls, predicts every result from a cycle-free model of
// the body kept in a scoreboard class, and compares each result field by
// field. G and dt are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module nbody_body_gravity_update_tb;
   import nbgu_pkg::*;

   localparam int FRAC     = 32;
   localparam int N_FIELDS = 11;
   localparam int WDOG_MAX = 60000;

   typedef struct {
      opcode_type op;
      word_type   mass;
      umag_type   radius;
      word_type   pos[3];
      word_type   vel[3];
   } step_item_type;

   typedef struct {
      word_type f[N_FIELDS];
   } body_view_type;

   // --------------------------------------------------------------------
   // Body predictor and expected result store
   // --------------------------------------------------------------------
   class body_tracker;
      umag_type      g_gain, dt;
      word_type      mass, pos[3], vel[3], acc[3];
      umag_type      radius;
      body_view_type expected_views[$];
      int            errors;

      function new();
         g_gain = 63'd1 << FRAC;
         dt     = 63'd1 << FRAC;
         mass   = '0;
         radius = '0;
         errors = 0;
         for (int i = 0; i < 3; i++) begin
            pos[i] = '0; vel[i] = '0; acc[i] = '0;
         end
      endfunction

      function void set_reg(regidx_type idx, umag_type v);
         if (idx == REG_GAIN) g_gain = v;
         else dt = v;
      endfunction

      static function word_type magn(word_type x);
         return x[63] ? -x : x;
      endfunction

      // signed result from a wide magnitude, saturated
      static function word_type signed_sat(bit neg, logic [127:0] m);
         if (neg) return (m > {64'd0, SIGN_WORD}) ? SIGN_WORD : -m[63:0];
         return (m > {64'd0, MAX_WORD}) ? MAX_WORD : m[63:0];
      endfunction

      static function word_type add_sat(word_type a, word_type b);
         word_type r;
         r = a + b;
         if (a[63] == b[63] && r[63] != a[63]) return a[63] ? SIGN_WORD : MAX_WORD;
         return r;
      endfunction

      static function word_type sub_sat(word_type a, word_type b);
         word_type r;
         r = a - b;
         if (a[63] != b[63] && r[63] != a[63]) return a[63] ? SIGN_WORD : MAX_WORD;
         return r;
      endfunction

      static function word_type fx_mul(word_type a, word_type b);
         logic [127:0] p;
         p = {64'd0, magn(a)} * {64'd0, magn(b)};
         return signed_sat(a[63] ^ b[63], p >> FRAC);
      endfunction

      static function word_type fx_umul(word_type a, word_type b);
         logic [127:0] p;
         p = ({64'd0, a} * {64'd0, b}) >> FRAC;
         return (p[127:64] != 0) ? '1 : p[63:0];
      endfunction

      static function word_type fx_div(word_type a, word_type d, bit neg);
         logic [127:0] n, q;
         if (magn(a) == 0) return '0;
         if (d == 0) return neg ? SIGN_WORD : MAX_WORD;
         n = {64'd0, magn(a)} << FRAC;
         q = n / {64'd0, d};
         return signed_sat(neg, q);
      endfunction

      static function word_type sqrt_floor(logic [127:0] s);
         word_type r, c;
         r = '0;
         for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= s) r = c;
         end
         return r;
      endfunction

      static function umag_type cbrt_merge(umag_type r1, umag_type r2);
         logic [191:0] t, cc;
         word_type     r, c;
         t = {129'd0, r1} * {129'd0, r1} * {129'd0, r1}
           + {129'd0, r2} * {129'd0, r2} * {129'd0, r2};
         r = '0;
         for (int b = 63; b >= 0; b--) begin
            c  = r | (64'd1 << b);
            cc = {128'd0, c} * {128'd0, c} * {128'd0, c};
            if (cc <= t) r = c;
         end
         return (r > MAX_WORD) ? MAX_WORD[62:0] : r[62:0];
      endfunction

      // distance vector to the other body and its exact squared length
      function logic [127:0] dist_sq(step_item_type it, output word_type d[3]);
         logic [127:0] s;
         s = '0;
         for (int i = 0; i < 3; i++) begin
            d[i] = sub_sat(it.pos[i], pos[i]);
            s += {64'd0, magn(d[i])} * {64'd0, magn(d[i])};
         end
         return s;
      endfunction

      function void accept_item(step_item_type it);
         word_type      d[3], r, r3, k, total, p;
         logic [127:0]  s;
         bit            coll, absb;
         body_view_type v;
         coll = 0;
         absb = 0;
         case (it.op)
            OP_LOAD: begin
               mass = it.mass;
               radius = it.radius;
               for (int i = 0; i < 3; i++) begin
                  pos[i] = it.pos[i]; vel[i] = it.vel[i]; acc[i] = '0;
               end
            end
            OP_CLEAR: for (int i = 0; i < 3; i++) acc[i] = '0;
            OP_GRAV: begin
               s = dist_sq(it, d);
               // zero distance leaves the acceleration alone
               if (s != 0) begin
                  r  = sqrt_floor(s);
                  r3 = fx_umul(fx_umul(r, r), r);
                  k  = fx_div(it.mass, r3, it.mass[63]);
                  for (int i = 0; i < 3; i++) acc[i] = add_sat(acc[i], fx_mul(d[i], k));
               end
            end
            OP_VEL: for (int i = 0; i < 3; i++)
               vel[i] = add_sat(vel[i], fx_mul(fx_mul(acc[i], {1'b0, g_gain}),
                                                {1'b0, dt}));
            OP_POS: for (int i = 0; i < 3; i++)
               pos[i] = add_sat(pos[i], fx_mul(vel[i], {1'b0, dt}));
            OP_COLL: begin
               s = dist_sq(it, d);
               coll = sqrt_floor(s) < ({1'b0, radius} + {1'b0, it.radius});
            end
            OP_ABSORB: begin
               // only a lighter or equal body is absorbed
               if ($signed(mass) >= $signed(it.mass)) begin
                  total  = add_sat(mass, it.mass);
                  radius = cbrt_merge(radius, it.radius);
                  if (total != 0) begin
                     for (int i = 0; i < 3; i++) begin
                        p = add_sat(fx_mul(vel[i], mass), fx_mul(it.vel[i], it.mass));
                        vel[i] = fx_div(p, magn(total), p[63] ^ total[63]);
                     end
                  end
                  mass = total;
                  absb = 1;
               end
            end
            default: mass = (mass == SIGN_WORD) ? MAX_WORD : -mass;
         endcase
         v.f[0] = mass;
         v.f[1] = {1'b0, radius};
         for (int i = 0; i < 3; i++) begin
            v.f[2 + i] = pos[i];
            v.f[5 + i] = vel[i];
         end
         v.f[8]  = {63'd0, (!mass[63] && mass != 0)};
         v.f[9]  = {63'd0, coll};
         v.f[10] = {63'd0, absb};
         expected_views.insert(expected_views.size(), v);
      endfunction

      function void check_result(body_view_type got);
         body_view_type want;
         string         names[N_FIELDS];
         names = '{"body_mass", "body_radius", "pos_x", "pos_y", "pos_z",
                   "vel_x", "vel_y", "vel_z", "is_active", "collided", "absorbed"};
         if (expected_views.size() == 0) begin
            $display("%0t: unexpected result item, mass %h", $time, got.f[0]);
            errors++;
            return;
         end
         want = expected_views.pop_front();
         foreach (want.f[i])
            if (want.f[i] !== got.f[i]) begin
               $display("%0t: %s mismatch, expected %h actual %h",
                        $time, names[i], want.f[i], got.f[i]);
               errors++;
            end
      endfunction
   endclass

   // --------------------------------------------------------------------
   // Clock, reset and block
   // --------------------------------------------------------------------
   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0, req_stall;
   opcode_type req_opcode = '0;
   sword_type  req_other_mass = '0, req_other_pos_x = '0, req_other_pos_y = '0;
   sword_type  req_other_pos_z = '0, req_other_vel_x = '0, req_other_vel_y = '0;
   sword_type  req_other_vel_z = '0;
   umag_type   req_other_radius = '0;
   logic       rsp_valid, rsp_stall = 0;
   sword_type  rsp_body_mass, rsp_pos_x, rsp_pos_y, rsp_pos_z;
   sword_type  rsp_vel_x, rsp_vel_y, rsp_vel_z;
   umag_type   rsp_body_radius;
   logic       rsp_is_active, rsp_collided, rsp_absorbed;
   logic       csr_valid = 0, csr_ready;
   regidx_type csr_index = REG_GAIN;
   umag_type   csr_wdata = '0;

   body_tracker body = new();
   bit          gaps_on = 1;
   int          quiet_cycles = 0;

   initial forever #2 clock = ~clock;

   nbody_body_gravity_update #(.FRAC_BITS(FRAC)) i_dut (.*);

   // output stalls and result checking
   always @(posedge clock) begin
      body_view_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.f = '{rsp_body_mass, {1'b0, rsp_body_radius}, rsp_pos_x, rsp_pos_y,
                   rsp_pos_z, rsp_vel_x, rsp_vel_y, rsp_vel_z, {63'd0, rsp_is_active},
                   {63'd0, rsp_collided}, {63'd0, rsp_absorbed}};
         body.check_result(got);
      end
      rsp_stall <= gaps_on && ($urandom_range(0, 99) < 37);
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)
          || reset)
         quiet_cycles <= 0;
      else if (quiet_cycles >= WDOG_MAX) begin
         $display("status: fail");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // --------------------------------------------------------------------
   // Drivers
   // --------------------------------------------------------------------
   task automatic send_step(step_item_type it);
      if (gaps_on && $urandom_range(0, 99) < 37) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid        <= 1;
      req_opcode       <= it.op;
      req_other_mass   <= it.mass;
      req_other_radius <= it.radius;
      req_other_pos_x  <= it.pos[0];
      req_other_pos_y  <= it.pos[1];
      req_other_pos_z  <= it.pos[2];
      req_other_vel_x  <= it.vel[0];
      req_other_vel_y  <= it.vel[1];
      req_other_vel_z  <= it.vel[2];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      body.accept_item(it);
   endtask

   // wait for the block to drain, then write one register
   task automatic write_reg(regidx_type idx, umag_type v);
      req_valid <= 0;
      while (body.expected_views.size() != 0) @(posedge clock);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      body.set_reg(idx, v);
   endtask

   // random word of varied magnitude, with the extremes now and then
   function automatic word_type rand_word();
      word_type w;
      case ($urandom_range(0, 11))
         0: return SIGN_WORD;
         1: return MAX_WORD;
         2: return '0;
         3: return 64'd1;
         default: begin
            w = {$urandom, $urandom};
            return $signed(w) >>> $urandom_range(0, 40);
         end
      endcase
   endfunction

   function automatic step_item_type make_step(opcode_type op);
      step_item_type it;
      it.op     = op;
      it.mass   = rand_word();
      it.radius = 63'({1'b0, rand_word()} >> $urandom_range(1, 40));
      for (int i = 0; i < 3; i++) begin
         it.pos[i] = rand_word();
         it.vel[i] = rand_word();
      end
      return it;
   endfunction

   function automatic opcode_type pick_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return OP_LOAD;
      if (r < 18) return OP_CLEAR;
      if (r < 40) return OP_GRAV;
      if (r < 55) return OP_VEL;
      if (r < 70) return OP_POS;
      if (r < 87) return OP_COLL;
      if (r < 91) return OP_ABSORB;
      return OP_DEACT;
   endfunction

   // --------------------------------------------------------------------
   // Stimulus
   // --------------------------------------------------------------------
   initial begin
      step_item_type it;
      umag_type      gains[4], steps[4];
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, each operation and the corner cases
      it = make_step(OP_LOAD);
      it.mass = 64'sd1 <<< 40; it.radius = '1;
      it.pos = '{SIGN_WORD, MAX_WORD, '0}; it.vel = '{MAX_WORD, SIGN_WORD, 64'd1};
      send_step(it);
      for (int o = 1; o < 8; o++) send_step(make_step(opcode_type'(o)));
      it = make_step(OP_LOAD);
      it.mass = 64'sd1 <<< 33; it.radius = 63'd1 << 32;
      it.pos = '{64'd5 << 32, 64'd7 << 32, '0}; it.vel = '{64'd1 << 30, '0, -(64'd1 << 31)};
      send_step(it);
      // zero distance gravity
      it.op = OP_GRAV; send_step(it);
      // tiny distance gravity, both signs of the other mass and zero
      it.pos[0] = it.pos[0] + 64'd1; send_step(it);
      it.mass = -it.mass; send_step(it);
      it.mass = '0; send_step(it);
      it.op = OP_VEL; send_step(it);
      it.op = OP_POS; send_step(it);
      it.op = OP_COLL; send_step(it);
      // heavier other body is not absorbed
      it = make_step(OP_ABSORB); it.mass = MAX_WORD; send_step(it);
      // zero total mass with oversized radii
      it = make_step(OP_LOAD); it.mass = 64'sd3 <<< 32; it.radius = '1; send_step(it);
      it.op = OP_ABSORB; it.mass = -(64'sd3 <<< 32); it.radius = '1; send_step(it);
      // deactivate the most negative mass
      it = make_step(OP_LOAD); it.mass = SIGN_WORD; send_step(it);
      it.op = OP_DEACT; send_step(it);

      // random phases over several G and dt settings
      gains = '{63'd1 << FRAC, '0, '1, 63'({$urandom, $urandom} >> 30)};
      steps = '{63'd1 << FRAC, '1, 63'd1, 63'({$urandom, $urandom} >> 30)};
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(REG_GAIN, gains[ph]);
         write_reg(REG_STEP, steps[ph]);
         for (int n = 0; n < 210; n++) begin
            gaps_on = !(ph == 2 && n >= 60 && n < 140);
            send_step(make_step(pick_op()));
         end
      end
      gaps_on = 1;
      req_valid <= 0;

      while (body.expected_views.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (body.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
